>>> rtl/jbsc_pkg.sv
// Package for the JPEG baseline stream checker: payload structs, parse phases,
// status codes and constants. No dependencies.
`timescale 1ns / 1ps
package jbsc_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [12:0] frame_width;
        logic [12:0] frame_height;
    } out_item_t;

    typedef enum logic [3:0] {
        PH_SOI0, PH_SOI1, PH_MARK, PH_FILL, PH_LENHI, PH_LENLO,
        PH_SEG, PH_ENT, PH_ENTFF, PH_OK, PH_ERR
    } phase_t;

    localparam logic [3:0] ST_OK       = 4'd0;
    localparam logic [3:0] ST_FILE     = 4'd1;
    localparam logic [3:0] ST_NOMARK   = 4'd2;
    localparam logic [3:0] ST_ENDFILL  = 4'd3;
    localparam logic [3:0] ST_EOI      = 4'd4;
    localparam logic [3:0] ST_BADMARK  = 4'd5;
    localparam logic [3:0] ST_ENDLEN   = 4'd6;
    localparam logic [3:0] ST_SEGLEN   = 4'd7;
    localparam logic [3:0] ST_SOFKIND  = 4'd8;
    localparam logic [3:0] ST_SOFFIELD = 4'd9;
    localparam logic [3:0] ST_SCAN     = 4'd10;
    localparam logic [3:0] ST_ENTFILL  = 4'd11;
    localparam logic [3:0] ST_ENTMARK  = 4'd12;
    localparam logic [3:0] ST_NOEND    = 4'd13;
    localparam logic [3:0] ST_DIM      = 4'd14;

    localparam logic [1:0] REG_MAX_BYTES = 2'd0;
    localparam logic [1:0] REG_EXP_W     = 2'd1;
    localparam logic [1:0] REG_EXP_H     = 2'd2;

    localparam int          CFG_W          = 24;
    localparam logic [23:0] MAX_BYTES_RST  = 24'd4194304;
    localparam logic [24:0] MIN_BYTES      = 25'd14;
    localparam logic [15:0] MAX_SIDE       = 16'd4096;
    localparam logic [31:0] MAX_AREA       = 32'd12000000;

    function automatic logic is_sof(input logic [7:0] m);
        return (m >= 8'hc0 && m <= 8'hc3) || (m >= 8'hc5 && m <= 8'hc7) ||
               (m >= 8'hc9 && m <= 8'hcb) || (m >= 8'hcd && m <= 8'hcf);
    endfunction

endpackage

>>> rtl/jbsc_sof_check.sv
// SOF0 field limit check: precision, component count, length and frame size.
// Depends on jbsc_pkg.
`timescale 1ns / 1ps
module jbsc_sof_check import jbsc_pkg::*; (
    input  logic [7:0]  precision,
    input  logic [7:0]  components,
    input  logic [15:0] seg_len,
    input  logic [15:0] width,
    input  logic [15:0] height,
    output logic        fields_ok
);
    logic [12:0] w13, h13;
    logic [25:0] area;
    logic [15:0] need_len;

    always_comb begin
        w13 = width[12:0];
        h13 = height[12:0];
        area = w13 * h13;
        need_len = 16'd8 + 16'(components) * 16'd3;
        fields_ok = precision == 8'd8 &&
                    (components == 8'd1 || components == 8'd3) &&
                    seg_len == need_len &&
                    width != 16'd0 && width <= MAX_SIDE &&
                    height != 16'd0 && height <= MAX_SIDE &&
                    {6'd0, area} <= MAX_AREA;
    end
endmodule

>>> rtl/jbsc_parser.sv
// Byte-at-a-time marker and segment parser; holds all per-file state and the
// next-state logic. Depends on jbsc_pkg and jbsc_sof_check.
`timescale 1ns / 1ps
module jbsc_parser import jbsc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  in_item_t    item,
    input  logic [23:0] max_image_bytes,
    input  logic [15:0] expected_width,
    input  logic [15:0] expected_height,
    output out_item_t   verdict
);
    phase_t      phase_reg, phase_next;
    logic [24:0] count_reg, count_next;
    logic [15:0] remain_reg, remain_next;
    logic [15:0] seglen_reg, seglen_next;
    logic [7:0]  lenhi_reg, lenhi_next;
    logic [7:0]  marker_reg, marker_next;
    logic [2:0]  fidx_reg, fidx_next;
    logic [7:0]  prec_reg, prec_next;
    logic [7:0]  comp_reg, comp_next;
    logic        frame_reg, frame_next;
    logic        scan_reg, scan_next;
    logic [15:0] hw_reg, hw_next;
    logic [15:0] hh_reg, hh_next;
    logic [3:0]  err_reg, err_next;
    logic [7:0]  prev_reg;
    logic        hbad_reg, hbad_next;

    logic [7:0]  b;
    logic        last;
    logic        fields_ok;
    logic        seg_end;
    logic [15:0] len_w;
    logic [15:0] chk_len;

    assign b = item.data_byte;
    assign last = item.last_byte;

    jbsc_sof_check u_sof (
        .precision (prec_next),
        .components(comp_next),
        .seg_len   (chk_len),
        .width     (hw_next),
        .height    (hh_next),
        .fields_ok (fields_ok)
    );

    always_comb begin
        phase_next = phase_reg;
        count_next = (count_reg <= {1'b0, max_image_bytes}) ? count_reg + 25'd1 : count_reg;
        remain_next = remain_reg;
        seglen_next = seglen_reg;
        lenhi_next = lenhi_reg;
        marker_next = marker_reg;
        fidx_next = fidx_reg;
        prec_next = prec_reg;
        comp_next = comp_reg;
        frame_next = frame_reg;
        scan_next = scan_reg;
        hw_next = hw_reg;
        hh_next = hh_reg;
        err_next = err_reg;
        hbad_next = hbad_reg;
        seg_end = 1'b0;
        len_w = {lenhi_reg, b};
        chk_len = seglen_reg;
        case (phase_reg)
            PH_SOI0: begin
                hbad_next = hbad_reg | (b != 8'hff);
                phase_next = PH_SOI1;
            end
            PH_SOI1: begin
                hbad_next = hbad_reg | (b != 8'hd8);
                phase_next = PH_MARK;
            end
            PH_MARK: begin
                if (b != 8'hff) begin
                    err_next = ST_NOMARK;
                    phase_next = PH_ERR;
                end else begin
                    phase_next = PH_FILL;
                end
            end
            PH_FILL: begin
                if (b == 8'hff) begin
                    phase_next = PH_FILL;
                end else if (b == 8'hd9) begin
                    if (last && frame_reg && scan_reg && hw_reg != 16'd0 && hh_reg != 16'd0) begin
                        phase_next = PH_OK;
                    end else begin
                        err_next = ST_EOI;
                        phase_next = PH_ERR;
                    end
                end else if (b == 8'hd8 || b == 8'h00 || b == 8'h01 ||
                             (b >= 8'hd0 && b <= 8'hd7)) begin
                    err_next = ST_BADMARK;
                    phase_next = PH_ERR;
                end else begin
                    marker_next = b;
                    phase_next = PH_LENHI;
                end
            end
            PH_LENHI: begin
                lenhi_next = b;
                phase_next = PH_LENLO;
            end
            PH_LENLO: begin
                seglen_next = len_w;
                chk_len = len_w;
                if (len_w < 16'd2) begin
                    err_next = ST_SEGLEN;
                    phase_next = PH_ERR;
                end else begin
                    remain_next = len_w - 16'd2;
                    fidx_next = 3'd0;
                    if (len_w == 16'd2) seg_end = 1'b1;
                    else phase_next = PH_SEG;
                end
            end
            PH_SEG: begin
                if (is_sof(marker_reg) && !frame_reg) begin
                    case (fidx_reg)
                        3'd0: prec_next = b;
                        3'd1: hh_next = {b, 8'd0};
                        3'd2: hh_next = {hh_reg[15:8], b};
                        3'd3: hw_next = {b, 8'd0};
                        3'd4: hw_next = {hw_reg[15:8], b};
                        3'd5: comp_next = b;
                        default: ;
                    endcase
                    if (fidx_reg < 3'd6) fidx_next = fidx_reg + 3'd1;
                end
                remain_next = remain_reg - 16'd1;
                if (remain_next == 16'd0) seg_end = 1'b1;
            end
            PH_ENT: begin
                if (b == 8'hff) phase_next = PH_ENTFF;
            end
            PH_ENTFF: begin
                if (b == 8'hff) begin
                    phase_next = PH_ENTFF;
                end else if (b == 8'h00 || (b >= 8'hd0 && b <= 8'hd7)) begin
                    phase_next = PH_ENT;
                end else if (b == 8'hd9 && last) begin
                    phase_next = PH_OK;
                end else begin
                    err_next = ST_ENTMARK;
                    phase_next = PH_ERR;
                end
            end
            default: ;
        endcase

        if (seg_end) begin
            if (is_sof(marker_reg) &&
                (marker_reg != 8'hc0 || frame_reg || chk_len < 16'd11)) begin
                err_next = ST_SOFKIND;
                phase_next = PH_ERR;
            end else if (is_sof(marker_reg) && !fields_ok) begin
                hw_next = 16'd0;
                hh_next = 16'd0;
                err_next = ST_SOFFIELD;
                phase_next = PH_ERR;
            end else begin
                if (is_sof(marker_reg)) frame_next = 1'b1;
                if (marker_reg != 8'hda) begin
                    phase_next = PH_MARK;
                end else if (!frame_next || scan_reg || chk_len < 16'd8) begin
                    err_next = ST_SCAN;
                    phase_next = PH_ERR;
                end else begin
                    scan_next = 1'b1;
                    phase_next = PH_ENT;
                end
            end
        end

        verdict.frame_width = 13'd0;
        verdict.frame_height = 13'd0;
        if (count_next < MIN_BYTES || count_next > {1'b0, max_image_bytes} ||
            hbad_next || prev_reg != 8'hff || b != 8'hd9) begin
            verdict.status = ST_FILE;
        end else begin
            if (frame_next) begin
                verdict.frame_width = hw_next[12:0];
                verdict.frame_height = hh_next[12:0];
            end
            case (phase_next)
                PH_ERR: verdict.status = err_next;
                PH_OK: begin
                    if (expected_width == 16'd0 || expected_height == 16'd0 ||
                        hw_next != expected_width || hh_next != expected_height)
                        verdict.status = ST_DIM;
                    else
                        verdict.status = ST_OK;
                end
                PH_FILL: verdict.status = ST_ENDFILL;
                PH_LENHI, PH_LENLO: verdict.status = ST_ENDLEN;
                PH_SEG: verdict.status = ST_SEGLEN;
                PH_ENTFF: verdict.status = ST_ENTFILL;
                default: verdict.status = ST_NOEND;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (step && last)) begin
            phase_reg <= PH_SOI0;
            count_reg <= '0;
            remain_reg <= '0;
            seglen_reg <= '0;
            lenhi_reg <= '0;
            marker_reg <= '0;
            fidx_reg <= '0;
            prec_reg <= '0;
            comp_reg <= '0;
            frame_reg <= 1'b0;
            scan_reg <= 1'b0;
            hw_reg <= '0;
            hh_reg <= '0;
            err_reg <= '0;
            prev_reg <= '0;
            hbad_reg <= 1'b0;
        end else if (step) begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            remain_reg <= remain_next;
            seglen_reg <= seglen_next;
            lenhi_reg <= lenhi_next;
            marker_reg <= marker_next;
            fidx_reg <= fidx_next;
            prec_reg <= prec_next;
            comp_reg <= comp_next;
            frame_reg <= frame_next;
            scan_reg <= scan_next;
            hw_reg <= hw_next;
            hh_reg <= hh_next;
            err_reg <= err_next;
            prev_reg <= b;
            hbad_reg <= hbad_next;
        end
    end
endmodule

>>> rtl/jpeg_baseline_stream_checker.sv
// Top level of the JPEG baseline stream checker: input register, config
// registers, parser and result register. Depends on jbsc_pkg and jbsc_parser.
//
//   channel | ports                          | moves
//   s_      | s_valid s_ready s_data         | one file byte + last flag
//   m_      | m_valid m_ready m_data         | one verdict per file
//   cfg     | cfg_we cfg_index cfg_data      | register write, no wait
//
// One byte per cycle while the input does not stall; a byte is registered in the
// input register, parsed from there, and its verdict (if last) is registered in the result register.
// The result register holds a verdict until taken; the input stalls only when
// a registered last byte would meet a full result register.
// Reset is synchronous, active low, and clears all control state.
`timescale 1ns / 1ps
module jpeg_baseline_stream_checker import jbsc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);
    logic        in_valid_reg;
    in_item_t    in_data_reg;
    logic        out_valid_reg;
    out_item_t   out_data_reg;
    logic [23:0] max_bytes_reg;
    logic [15:0] exp_w_reg, exp_h_reg;
    out_item_t   verdict;
    logic        step;

    assign step = in_valid_reg && (!in_data_reg.last_byte || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || step;
    assign m_valid = out_valid_reg;
    assign m_data = out_data_reg;

    jbsc_parser u_parser (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step           (step),
        .item           (in_data_reg),
        .max_image_bytes(max_bytes_reg),
        .expected_width (exp_w_reg),
        .expected_height(exp_h_reg),
        .verdict        (verdict)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            max_bytes_reg <= MAX_BYTES_RST;
            exp_w_reg <= '0;
            exp_h_reg <= '0;
        end else begin
            if (s_ready) in_valid_reg <= s_valid;
            if (step && in_data_reg.last_byte) out_valid_reg <= 1'b1;
            else if (m_ready) out_valid_reg <= 1'b0;
            if (cfg_we) begin
                case (cfg_index)
                    REG_MAX_BYTES: max_bytes_reg <= cfg_data[23:0];
                    REG_EXP_W:     exp_w_reg <= cfg_data[15:0];
                    REG_EXP_H:     exp_h_reg <= cfg_data[15:0];
                    default: ;
                endcase
            end
        end
        if (s_ready && s_valid) in_data_reg <= s_data;
        if (step && in_data_reg.last_byte) out_data_reg <= verdict;
    end
endmodule

>>> rtl/jbsc_checker.sv
// Port-level checker for the JPEG baseline stream checker, bound to the top.
// Depends on jbsc_pkg.
`timescale 1ns / 1ps
module jbsc_checker import jbsc_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_item_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.status <= ST_DIM)
        else $error("status out of range");

    a_file_zero_dims: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == ST_FILE |->
        m_data.frame_width == 13'd0 && m_data.frame_height == 13'd0)
        else $error("whole-file error with dimensions");

    a_ready_after_reset: assert property (@(posedge aclk)
        !aresetn |=> s_ready && !m_valid)
        else $error("not idle after reset");
endmodule

bind jpeg_baseline_stream_checker jbsc_checker u_jbsc_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .s_data(s_data), .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
);

>>> tb/sv/jbsc_checker.sv
// Checker for the JPEG baseline stream checker: watches all three channels,
// predicts each file verdict from the accepted bytes and compares. Depends on jbsc_pkg.
`timescale 1ns / 1ps
module jbsc_scoreboard import jbsc_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_ready,
    input  in_item_t         s_data,
    input  logic             m_valid,
    input  logic             m_ready,
    input  out_item_t        m_data,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    output int               fail_count,
    output int               verdicts_pending
);

    logic [23:0] lim_bytes;
    logic [15:0] man_w, man_h;

    phase_t      ph;
    logic [24:0] nbytes;
    logic [15:0] seg_left, seg_len;
    logic [7:0]  len_hi, cur_mark, prev_b, prec, ncomp;
    logic [2:0]  fld;
    logic        got_frame, got_scan, hdr_bad;
    logic [15:0] hw, hh;
    logic [3:0]  err_code;

    out_item_t   verdict_q[$];
    int          mism;

    function automatic logic sof_kind(input logic [7:0] m);
        return (m >= 8'hc0 && m <= 8'hc3) || (m >= 8'hc5 && m <= 8'hc7) ||
               (m >= 8'hc9 && m <= 8'hcb) || (m >= 8'hcd && m <= 8'hcf);
    endfunction

    task automatic clear_parse();
        ph = PH_SOI0; nbytes = '0; seg_left = '0; seg_len = '0; len_hi = '0;
        cur_mark = '0; fld = '0; prec = '0; ncomp = '0; got_frame = 1'b0;
        got_scan = 1'b0; hw = '0; hh = '0; err_code = '0; prev_b = '0;
        hdr_bad = 1'b0;
    endtask

    task automatic flag(input logic [3:0] c);
        err_code = c;
        ph = PH_ERR;
    endtask

    task automatic close_segment();
        if (sof_kind(cur_mark)) begin
            if (cur_mark != 8'hc0 || got_frame || seg_len < 11) begin
                flag(ST_SOFKIND);
                return;
            end
            if (prec != 8 || (ncomp != 1 && ncomp != 3) ||
                    seg_len != 16'(8 + 3 * ncomp) || hw == 0 || hw > MAX_SIDE ||
                    hh == 0 || hh > MAX_SIDE ||
                    64'(hw) * 64'(hh) > 64'(MAX_AREA)) begin
                hw = '0; hh = '0;
                flag(ST_SOFFIELD);
                return;
            end
            got_frame = 1'b1;
        end
        if (cur_mark != 8'hda) begin
            ph = PH_MARK;
            return;
        end
        if (!got_frame || got_scan || seg_len < 8) begin
            flag(ST_SCAN);
            return;
        end
        got_scan = 1'b1;
        ph = PH_ENT;
    endtask

    task automatic parse(input logic [7:0] b, input logic last);
        case (ph)
            PH_SOI0: begin hdr_bad |= (b != 8'hff); ph = PH_SOI1; end
            PH_SOI1: begin hdr_bad |= (b != 8'hd8); ph = PH_MARK; end
            PH_MARK: if (b != 8'hff) flag(ST_NOMARK); else ph = PH_FILL;
            PH_FILL: begin
                if (b == 8'hff) begin
                end else if (b == 8'hd9) begin
                    if (last && got_frame && got_scan && hw != 0 && hh != 0)
                        ph = PH_OK;
                    else
                        flag(ST_EOI);
                end else if (b == 8'hd8 || b == 8'h00 || b == 8'h01 ||
                        (b >= 8'hd0 && b <= 8'hd7)) begin
                    flag(ST_BADMARK);
                end else begin
                    cur_mark = b;
                    ph = PH_LENHI;
                end
            end
            PH_LENHI: begin len_hi = b; ph = PH_LENLO; end
            PH_LENLO: begin
                seg_len = {len_hi, b};
                if (seg_len < 2) begin
                    flag(ST_SEGLEN);
                end else begin
                    seg_left = seg_len - 16'd2;
                    fld = '0;
                    if (seg_left == 0) close_segment();
                    else ph = PH_SEG;
                end
            end
            PH_SEG: begin
                if (sof_kind(cur_mark) && !got_frame) begin
                    case (fld)
                        3'd0: prec = b;
                        3'd1: hh = {b, 8'h00};
                        3'd2: hh[7:0] = b;
                        3'd3: hw = {b, 8'h00};
                        3'd4: hw[7:0] = b;
                        3'd5: ncomp = b;
                        default: ;
                    endcase
                    if (fld < 6) fld++;
                end
                seg_left--;
                if (seg_left == 0) close_segment();
            end
            PH_ENT: if (b == 8'hff) ph = PH_ENTFF;
            PH_ENTFF: begin
                if (b == 8'hff) begin
                end else if (b == 8'h00 || (b >= 8'hd0 && b <= 8'hd7))
                    ph = PH_ENT;
                else if (b == 8'hd9 && last)
                    ph = PH_OK;
                else
                    flag(ST_ENTMARK);
            end
            default: ;
        endcase
    endtask

    task automatic take_byte(input logic [7:0] b, input logic last);
        out_item_t v;
        if (nbytes <= {1'b0, lim_bytes}) nbytes++;
        parse(b, last);
        if (!last) begin
            prev_b = b;
            return;
        end
        v = '0;
        if (nbytes < MIN_BYTES || nbytes > {1'b0, lim_bytes} || hdr_bad ||
                prev_b != 8'hff || b != 8'hd9) begin
            v.status = ST_FILE;
        end else begin
            if (got_frame) begin
                v.frame_width = hw[12:0];
                v.frame_height = hh[12:0];
            end
            if (ph == PH_ERR) v.status = err_code;
            else if (ph != PH_OK) begin
                case (ph)
                    PH_FILL: v.status = ST_ENDFILL;
                    PH_LENHI, PH_LENLO: v.status = ST_ENDLEN;
                    PH_SEG: v.status = ST_SEGLEN;
                    PH_ENTFF: v.status = ST_ENTFILL;
                    default: v.status = ST_NOEND;
                endcase
            end else if (man_w == 0 || man_h == 0 || hw != man_w || hh != man_h)
                v.status = ST_DIM;
            else
                v.status = ST_OK;
        end
        verdict_q.push_back(v);
        clear_parse();
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            lim_bytes <= MAX_BYTES_RST;
            man_w = '0;
            man_h = '0;
            clear_parse();
        end else begin
            if (m_valid && m_ready) begin
                if (verdict_q.size() == 0) begin
                    mism++;
                    if (mism <= 10)
                        $display("unexpected verdict %p", m_data);
                end else begin
                    out_item_t e;
                    e = verdict_q.pop_front();
                    if (e.status != m_data.status || e.frame_width != m_data.frame_width
                            || e.frame_height != m_data.frame_height) begin
                        mism++;
                        if (mism <= 10)
                            $display("verdict mismatch: expected %p actual %p", e, m_data);
                    end
                end
            end
            if (s_valid && s_ready) take_byte(s_data.data_byte, s_data.last_byte);
            if (cfg_we) begin
                case (cfg_index)
                    REG_MAX_BYTES: lim_bytes <= cfg_data[23:0];
                    REG_EXP_W: man_w = cfg_data[15:0];
                    REG_EXP_H: man_h = cfg_data[15:0];
                    default: ;
                endcase
            end
        end
        fail_count <= mism;
        verdicts_pending <= verdict_q.size();
    end

    initial begin
        mism = 0;
        fail_count = 0;
        verdicts_pending = 0;
        lim_bytes = MAX_BYTES_RST;
        man_w = '0;
        man_h = '0;
    end

endmodule

>>> tb/sv/jpeg_baseline_stream_checker_tb.sv
// Testbench top for the JPEG baseline stream checker: clock, reset, file
// stimulus, configuration phases and verdict. Depends on jbsc_pkg, jbsc_checker.
`timescale 1ns / 1ps
module jpeg_baseline_stream_checker_tb;
    import jbsc_pkg::*;

    logic             aclk, aresetn;
    logic             s_valid, s_ready, m_valid, m_ready;
    in_item_t         s_data;
    out_item_t        m_data;
    logic             cfg_we;
    logic [1:0]       cfg_index;
    logic [CFG_W-1:0] cfg_data;
    int               fails, pending;
    int               sent;
    longint           cycles;
    logic [7:0]       fbuf[$];
    logic [15:0]      cur_w, cur_h;

    jpeg_baseline_stream_checker u_top (.*);

    jbsc_scoreboard u_chk (.*, .fail_count(fails), .verdicts_pending(pending));

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > 2000000) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // receiver: random stall per verdict
    initial begin
        int w;
        m_ready = 0;
        forever begin
            w = $urandom_range(0, 19);
            if ($urandom_range(0, 3) == 0) w = 0;
            repeat (w) @(negedge aclk);
            m_ready <= 1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            @(negedge aclk);
            m_ready <= 0;
        end
    end

    task automatic send_file(input bit burst);
        int g;
        for (int i = 0; i < fbuf.size(); i++) begin
            g = burst ? 0 : $urandom_range(0, 19);
            if (g != 0) begin
                s_valid <= 0;
                repeat (g) @(negedge aclk);
            end
            s_data.data_byte <= fbuf[i];
            s_data.last_byte <= (i == fbuf.size() - 1);
            s_valid <= 1;
            @(posedge aclk);
            while (!s_ready) @(posedge aclk);
            sent++;
            @(negedge aclk);
        end
        s_valid <= 0;
    endtask

    task automatic push16(input logic [15:0] v);
        fbuf.push_back(v[15:8]);
        fbuf.push_back(v[7:0]);
    endtask

    // build a well-formed file, then perhaps damage it
    task automatic build_file(input logic [15:0] w, input logic [15:0] h,
                              input int damage);
        int nc, ne, k;
        fbuf.delete();
        push16(16'hffd8);
        if ($urandom_range(0, 1)) begin
            push16(16'hffe0);
            k = $urandom_range(0, 4);
            push16(16'(k + 2));
            repeat (k) fbuf.push_back(8'($urandom));
        end
        nc = $urandom_range(0, 1) ? 3 : 1;
        fbuf.push_back(8'hff);
        if ($urandom_range(0, 3) == 0) fbuf.push_back(8'hff);
        fbuf.push_back(8'hc0);
        push16(16'(8 + 3 * nc));
        fbuf.push_back(8'd8);
        push16(h);
        push16(w);
        fbuf.push_back(nc[7:0]);
        repeat (3 * nc) fbuf.push_back(8'($urandom));
        push16(16'hffda);
        push16(16'd8);
        repeat (6) fbuf.push_back(8'($urandom));
        ne = $urandom_range(0, 12);
        repeat (ne) begin
            k = $urandom_range(0, 5);
            if (k == 0) begin
                push16(16'hff00);
            end else if (k == 1) begin
                fbuf.push_back(8'hff);
                fbuf.push_back(8'hd0 + 8'($urandom_range(0, 7)));
            end else begin
                fbuf.push_back(8'($urandom_range(0, 254)));
            end
        end
        push16(16'hffd9);
        if (damage == 1) begin
            k = $urandom_range(0, fbuf.size() - 1);
            fbuf[k] = 8'($urandom);
        end else if (damage == 2) begin
            k = $urandom_range(1, fbuf.size() - 1);
            while (fbuf.size() > k) void'(fbuf.pop_back());
        end else if (damage == 3) begin
            k = $urandom_range(0, fbuf.size() - 1);
            fbuf[k] = $urandom_range(0, 1) ? 8'hff : 8'hd9;
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] v);
        cfg_index <= idx;
        cfg_data <= v;
        cfg_we <= 1;
        @(negedge aclk);
        cfg_we <= 0;
    endtask

    task automatic settle();
        while (pending != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic noise_file(input int n);
        fbuf.delete();
        repeat (n) fbuf.push_back(8'($urandom));
    endtask

    initial begin
        logic [15:0] w, h;
        int n, d;
        s_valid = 0;
        s_data = '0;
        cfg_we = 0;
        cfg_index = REG_MAX_BYTES;
        cfg_data = '0;
        sent = 0;
        aresetn = 0;
        repeat (11) @(negedge aclk);
        aresetn = 1;
        @(negedge aclk);

        // directed: default registers, then matched manifest
        build_file(16'd16, 16'd8, 0); send_file(0);
        settle();
        write_reg(REG_EXP_W, 24'd16);
        write_reg(REG_EXP_H, 24'd8);
        build_file(16'd16, 16'd8, 0); send_file(1);
        build_file(16'd4096, 16'd2929, 0); send_file(0);
        build_file(16'd4096, 16'd4096, 0); send_file(0);
        build_file(16'd0, 16'd8, 0); send_file(0);
        build_file(16'd4097, 16'd1, 0); send_file(0);
        build_file(16'hffff, 16'hffff, 0); send_file(0);
        fbuf = '{8'hff, 8'hd9}; send_file(0);
        fbuf = '{8'hff}; send_file(0);
        fbuf = '{8'hff, 8'hd8, 8'hff, 8'hd9}; send_file(0);
        fbuf = '{8'hff, 8'hd8, 8'hff, 8'hc4, 8'h00, 8'h01, 8'h00, 8'h00,
                 8'h00, 8'h00, 8'h00, 8'h00, 8'hff, 8'hd9}; send_file(0);
        fbuf = '{8'hff, 8'hd8, 8'hff, 8'hda, 8'h00, 8'h08, 8'h00, 8'h00,
                 8'h00, 8'h00, 8'h00, 8'h00, 8'hff, 8'hd9}; send_file(0);
        fbuf = '{8'hff, 8'hd8, 8'hff, 8'hc1, 8'h00, 8'h0b, 8'h08, 8'h00,
                 8'h08, 8'h00, 8'h08, 8'h01, 8'h11, 8'h00, 8'hff, 8'hd9};
        send_file(0);
        fbuf = '{8'hff, 8'hd8, 8'hff, 8'he1, 8'hff, 8'hff, 8'h00, 8'h00,
                 8'h00, 8'h00, 8'h00, 8'h00, 8'hff, 8'hd9}; send_file(0);
        fbuf = '{8'hff, 8'hd8, 8'h12, 8'hff, 8'hff, 8'hff, 8'h01, 8'h00,
                 8'h00, 8'h00, 8'h00, 8'h00, 8'hff, 8'hd9}; send_file(0);
        settle();
        write_reg(REG_MAX_BYTES, 24'd14);
        build_file(16'd16, 16'd8, 0); send_file(0);
        fbuf = '{8'hff, 8'hd8, 8'hff, 8'hfe, 8'h00, 8'h08, 8'h00, 8'h00,
                 8'h00, 8'h00, 8'h00, 8'h00, 8'hff, 8'hd9}; send_file(0);
        settle();
        write_reg(REG_MAX_BYTES, 24'hffffff);
        write_reg(REG_EXP_W, 24'hffff);
        write_reg(REG_EXP_H, 24'd0);
        build_file(16'd16, 16'd8, 0); send_file(0);

        // random phases
        for (int p = 0; p < 6; p++) begin
            settle();
            cur_w = 16'($urandom_range(1, 64));
            cur_h = 16'($urandom_range(1, 64));
            write_reg(REG_EXP_W, (p == 5) ? 24'hffff : 24'(cur_w));
            write_reg(REG_EXP_H, (p == 4) ? 24'd0 : 24'(cur_h));
            write_reg(REG_MAX_BYTES, (p == 2) ? 24'd40 : (p == 3) ? 24'd14 :
                      24'($urandom_range(60, 100000)));
            n = sent;
            while (sent < n + 250) begin
                d = $urandom_range(0, 9);
                if (d < 5) begin
                    w = $urandom_range(0, 2) ? cur_w : 16'($urandom_range(0, 4200));
                    h = $urandom_range(0, 2) ? cur_h : 16'($urandom_range(0, 4200));
                    build_file(w, h, (d < 3) ? 0 : $urandom_range(1, 3));
                end else if (d < 9) begin
                    build_file(cur_w, cur_h, 0);
                end else begin
                    noise_file($urandom_range(1, 30));
                end
                send_file($urandom_range(0, 3) == 0);
            end
        end

        settle();
        repeat (20) @(negedge aclk);
        if (fails == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> filelist.f
rtl/jbsc_pkg.sv
rtl/jbsc_sof_check.sv
rtl/jbsc_parser.sv
rtl/jpeg_baseline_stream_checker.sv
rtl/jbsc_checker.sv
tb/sv/jbsc_checker.sv
tb/sv/jpeg_baseline_stream_checker_tb.sv
